@@ rtl/core/lgrs_pkg.sv @@
package lgrs_pkg;

  // Fixed field widths of the stream and configuration ports, column limits and job queue depth
  localparam int ROW_W       = 64;
  localparam int CFG_W       = 7;
  localparam int COLS_MAX    = 64;
  localparam int COLS_RESET  = 64;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [ROW_W-1:0] row_word_t;
  typedef logic [CFG_W-1:0] cfg_cols_t;

endpackage

@@ rtl/core/lgrs_front.sv @@
module lgrs_front #(
  parameter int COLS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  lgrs_pkg::row_word_t     in_tdata,   // row_cells
  input  logic                    in_tlast,   // last_row
  input  logic [COLS-1:0]         col_mask,
  output logic                    push_valid,
  input  logic                    push_ready,
  output logic [3*COLS+1:0]       push_data   // up, mid, down, last, split
);
  import lgrs_pkg::*;

  logic [COLS-1:0] above_r, above_nxt;
  logic [COLS-1:0] middle_r, middle_nxt;
  logic            have_row_r, have_row_nxt;
  logic [COLS-1:0] cur;
  logic            acc;

  // Classify the incoming row: buffer only, one job, or a job with a tail
  always_comb begin
    cur        = in_tdata[COLS-1:0] & col_mask;
    in_tready  = push_ready;
    acc        = in_tvalid & push_ready;
    push_valid = in_tvalid & (have_row_r | in_tlast);
    if (have_row_r) begin
      push_data = {in_tlast, in_tlast, cur, middle_r, above_r};
    end else begin
      push_data = {1'b0, 1'b1, {COLS{1'b0}}, cur, {COLS{1'b0}}};
    end
  end

  // Row buffers; a last row clears them for the next grid
  always_comb begin
    above_nxt    = above_r;
    middle_nxt   = middle_r;
    have_row_nxt = have_row_r;
    if (acc) begin
      if (in_tlast) begin
        above_nxt    = '0;
        middle_nxt   = '0;
        have_row_nxt = 1'b0;
      end else begin
        above_nxt    = middle_r;
        middle_nxt   = cur;
        have_row_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r    <= '0;
      middle_r   <= '0;
      have_row_r <= 1'b0;
    end else begin
      above_r    <= above_nxt;
      middle_r   <= middle_nxt;
      have_row_r <= have_row_nxt;
    end
  end

`ifndef SYNTHESIS
  // With no row buffered both buffers must be dead
  a_empty_buffers: assert property (@(posedge clk) disable iff (!rst_n)
    !have_row_r |-> (above_r == '0 && middle_r == '0))
    else $error("row buffers not clear while empty");
`endif

endmodule

@@ rtl/core/lgrs_queue.sv @@
module lgrs_queue #(
  parameter int WIDTH = 194,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import lgrs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_fire, pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push_fire  = push_valid & push_ready;
  assign pop_fire   = pop_valid & pop_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_fire && pop_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  // A lone push grows the fill by exactly one
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill did not advance on push");
`endif

endmodule

@@ rtl/core/lgrs_back.sv @@
module lgrs_back #(
  parameter int COLS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  logic [3*COLS+1:0]       pop_data,
  input  logic [COLS-1:0]         col_mask,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output lgrs_pkg::row_word_t     out_tdata,  // next_row
  output logic                    out_tlast   // is_last
);
  import lgrs_pkg::*;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  typedef enum logic [1:0] {
    PH_MAIN = 2'b01,
    PH_TAIL = 2'b10
  } back_phase_t;

  back_phase_t     phase_r, phase_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [COLS-1:0] out_row_r;
  logic            out_last_r;
  logic [COLS-1:0] job_up, job_mid, job_down;
  logic            job_last, job_split;
  logic [COLS-1:0] row_a, row_b, row_c;
  logic [COLS-1:0] res;
  logic            load;

  // One generation step for a row, neighbors outside the grid dead
  function automatic logic [COLS-1:0] life_row(input logic [COLS-1:0] a,
                                               input logic [COLS-1:0] b,
                                               input logic [COLS-1:0] c);
    logic [COLS+1:0] pa, pb, pc;
    logic [COLS-1:0] r;
    logic [3:0]      cnt;
    pa = {1'b0, a, 1'b0};
    pb = {1'b0, b, 1'b0};
    pc = {1'b0, c, 1'b0};
    for (int j = 0; j < COLS; j++) begin
      cnt = 4'(pa[j]) + 4'(pa[j+1]) + 4'(pa[j+2]) + 4'(pb[j]) + 4'(pb[j+2])
          + 4'(pc[j]) + 4'(pc[j+1]) + 4'(pc[j+2]);
      if (pb[j+1]) begin
        r[j] = (cnt == KEEP_COUNT) || (cnt == BIRTH_COUNT);
      end else begin
        r[j] = (cnt == BIRTH_COUNT);
      end
    end
    return r;
  endfunction

  assign job_up    = pop_data[COLS-1:0];
  assign job_mid   = pop_data[2*COLS-1:COLS];
  assign job_down  = pop_data[3*COLS-1:2*COLS];
  assign job_last  = pop_data[3*COLS];
  assign job_split = pop_data[3*COLS+1];

  // Tail pass evaluates the last row with a dead row below
  always_comb begin
    load      = pop_valid & (~out_valid_r | out_tready);
    pop_ready = load & ((phase_r == PH_TAIL) | ~job_split);
    if (phase_r == PH_TAIL) begin
      row_a = job_mid;
      row_b = job_down;
      row_c = '0;
    end else begin
      row_a = job_up;
      row_b = job_mid;
      row_c = job_down;
    end
    // buffered rows may predate a width change, so mask them with the current width
    res = life_row(row_a & col_mask, row_b & col_mask, row_c & col_mask) & col_mask;
  end

  // Phase sequencer
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_MAIN: begin
        if (load && job_split) phase_nxt = PH_TAIL;
      end
      PH_TAIL: begin
        if (load) phase_nxt = PH_MAIN;
      end
      default: phase_nxt = PH_MAIN;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAIN;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_row_r  <= res;
      out_last_r <= (phase_r == PH_TAIL) | (job_last & ~job_split);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ROW_W'(out_row_r);
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // The tail pass works on the entry still held at the queue head
  a_tail_holds_job: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TAIL) |-> pop_valid)
    else $error("tail pass without a queued job");

  // The first half of a split job is never marked last
  a_split_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && phase_r == PH_MAIN && job_split) |=> (out_tvalid && !out_tlast))
    else $error("first result of a last row marked last");
`endif

endmodule

@@ rtl/core/life_generation_row_stream.sv @@
// Channel | Dir | tdata              | tlast    | Handshake
// in_     | in  | row_cells[63:0]    | last_row | in_tvalid / in_tready
// out_    | out | next_row[63:0]     | is_last  | out_tvalid / out_tready
// cfg_    | in  | cols_in_use[6:0]   | -        | cfg_wen, no wait
// One row is taken per cycle while the queue has room; results are registered at the output.
// A last row after a buffered row yields two results, a main pass and a tail pass of its job.
// The four-entry job queue lets the input keep flowing while the output stalls, until it fills.
// Reset (rst_n low, synchronous) clears the row buffers and sets 64 columns.
module life_generation_row_stream #(
  parameter int COLS = lgrs_pkg::COLS_MAX
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  lgrs_pkg::row_word_t  in_tdata,   // row_cells
  input  logic                 in_tlast,   // last_row
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output lgrs_pkg::row_word_t  out_tdata,  // next_row
  output logic                 out_tlast,  // is_last
  input  logic                 cfg_wen,
  input  lgrs_pkg::cfg_cols_t  cfg_wdata   // cols_in_use
);
  import lgrs_pkg::*;

  localparam int JOB_W = 3 * COLS + 2;

  cfg_cols_t        cols_r;
  cfg_cols_t        live;
  logic [COLS-1:0]  col_mask;
  logic             push_valid, push_ready;
  logic [JOB_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [JOB_W-1:0] pop_data;

  // Column count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CFG_W'(COLS_RESET);
    end else if (cfg_wen) begin
      cols_r <= cfg_wdata;
    end
  end

  // Clamp to 1..COLS and build the live-column mask
  always_comb begin
    if (cols_r == '0) begin
      live = CFG_W'(1);
    end else if (cols_r > CFG_W'(COLS)) begin
      live = CFG_W'(COLS);
    end else begin
      live = cols_r;
    end
    for (int j = 0; j < COLS; j++) begin
      col_mask[j] = (CFG_W'(j) < live);
    end
  end

  lgrs_front #(.COLS(COLS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .col_mask   (col_mask),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lgrs_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lgrs_back #(.COLS(COLS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .col_mask   (col_mask),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
